// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_DEL_BACK  = 4'd4,
        OP_DEL_AT    = 4'd5,
        OP_SEARCH    = 4'd6,
        OP_DUMP_FWD  = 4'd7,
        OP_DUMP_BACK = 4'd8
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_NOPOS    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4,
        ST_FOUND    = 3'd5,
        ST_NOTFOUND = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch the incoming word
        logic exec;       // carry out the latched operation
        logic dump_next;  // emit the next dump element
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;   // output register can take a word this cycle
        logic dump_multi;  // latched op is a dump of two or more elements
        logic dump_final;  // element about to be emitted is the last one
    } sts_t;

endpackage

// ===== rtl/positional_list_engine_core.sv =====
// Top level of the positional list engine: controller plus datapath.
//
// Ordered list of up to 16 signed 32-bit words held in a row of register
// cells, front element in cell 0. An input word carries an opcode: insert at
// front, back or before a 1-based position; delete from front, back or a
// position (the removed word is returned); search; dump forward or backward.
// Every operation gives one output word, except a dump, which gives one word
// per element with last set on the final one (an empty list dumps as one
// EMPTY word). Opcodes 9 to 15 are dropped without output. An input word is
// captured, then executed; inserts and deletes shift all cells at once and a
// search compares all cells at once. A dump holds the input side until its
// last element is emitted, since the single cell read port emits one element
// a cycle while the output side is not stalled.
// element_count reports the occupancy after the operation.
module positional_list_engine_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         opcode,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] result_value,
    output logic [4:0]         element_count,
    output logic               last
);
    import ple_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing: idle / execute / dump streaming
    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // cells, count and output register
    ple_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_value  (result_value),
        .element_count (element_count),
        .last          (last)
    );

endmodule

// ===== rtl/ple_ctrl.sv =====
// Sequencing state machine for the positional list engine.
module ple_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ple_pkg::sts_t sts,
    output ple_pkg::cmd_t cmd
);
    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && sts.slot_free)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.dump_multi ? S_DUMP : S_IDLE;
            end
            S_DUMP:
            begin
                if (sts.slot_free && sts.dump_final)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.dump_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = sts.slot_free;
                cmd.capture = in_valid && sts.slot_free;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_DUMP:
            begin
                cmd.dump_next = sts.slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ple_datapath.sv =====
// List cells, element count, operand latch and output register.
module ple_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ple_pkg::cmd_t      cmd,
    output ple_pkg::sts_t      sts,
    input  logic [3:0]         opcode,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] result_value,
    output logic [4:0]         element_count,
    output logic               last
);
    import ple_pkg::*;

    logic [31:0]      cell_reg [DEPTH];
    logic [31:0]      cell_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    opcode_t     op_reg;
    logic [31:0] val_reg;
    logic [7:0]  pos_reg;
    logic [IDX_W-1:0] step_reg;

    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_value_reg;
    logic [4:0]  out_count_reg;
    logic        out_last_reg;

    logic             is_full;
    logic             is_empty;
    logic             pos_zero;
    logic             pos_past;
    logic [7:0]       pos_m1;
    logic [CNT_W-1:0] count_m1;
    logic [IDX_W-1:0] step_cur;
    logic [IDX_W-1:0] rd_idx;
    logic [31:0]      rd_data;
    logic             hit;

    logic             has_res;
    status_t          res_status;
    logic [31:0]      res_value;
    logic             res_last;
    logic             do_ins;
    logic             do_del;
    logic [IDX_W-1:0] ins_idx;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign pos_zero = (pos_reg == 8'd0);
    assign pos_past = ({1'b0, pos_reg} > 9'(count_reg));
    assign pos_m1   = pos_reg - 8'd1;
    assign count_m1 = count_reg - CNT_W'(1);
    assign step_cur = cmd.exec ? '0 : step_reg;

    // single read port: element to delete, or the dump element due now
    always_comb
    begin
        case (op_reg)
            OP_DEL_FRONT: rd_idx = '0;
            OP_DEL_BACK:  rd_idx = count_m1[IDX_W-1:0];
            OP_DEL_AT:    rd_idx = pos_m1[IDX_W-1:0];
            OP_DUMP_BACK: rd_idx = count_m1[IDX_W-1:0] - step_cur;
            default:      rd_idx = step_cur;
        endcase
    end

    assign rd_data = cell_reg[rd_idx];

    // every occupied cell compared at once
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if ((CNT_W'(i) < count_reg) && (cell_reg[i] == val_reg))
            begin
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        has_res    = 1'b1;
        res_status = ST_OK;
        res_value  = '0;
        res_last   = 1'b1;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        ins_idx    = '0;
        case (op_reg) inside
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (is_full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_ins    = 1'b1;
                    ins_idx   = (op_reg == OP_INS_FRONT) ? '0 : count_reg[IDX_W-1:0];
                    res_value = val_reg;
                end
            end
            OP_INS_AT:
            begin
                if (pos_zero)
                begin
                    res_status = ST_BADPOS;
                end
                else if (is_empty)
                begin
                    do_ins    = 1'b1;
                    res_value = val_reg;
                end
                else if (pos_past)
                begin
                    res_status = ST_NOPOS;
                end
                else if (is_full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_ins    = 1'b1;
                    ins_idx   = pos_m1[IDX_W-1:0];
                    res_value = val_reg;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (is_empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    do_del    = 1'b1;
                    res_value = rd_data;
                end
            end
            OP_DEL_AT:
            begin
                if (pos_zero)
                begin
                    res_status = ST_BADPOS;
                end
                else if (is_empty)
                begin
                    res_status = ST_EMPTY;
                end
                else if (pos_past)
                begin
                    res_status = ST_NOPOS;
                end
                else
                begin
                    do_del    = 1'b1;
                    res_value = rd_data;
                end
            end
            OP_SEARCH:
            begin
                if (is_empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_status = hit ? ST_FOUND : ST_NOTFOUND;
                end
            end
            OP_DUMP_FWD, OP_DUMP_BACK:
            begin
                if (is_empty)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_value = rd_data;
                    res_last  = (count_reg == CNT_W'(1));
                end
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    // shift network: open a gap on insert, close it on delete
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.exec && do_ins)
            begin
                if (IDX_W'(i) == ins_idx)
                begin
                    cell_next[i] = val_reg;
                end
                else if ((i > 0) && (IDX_W'(i) > ins_idx))
                begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (cmd.exec && do_del && (i < DEPTH - 1) && (IDX_W'(i) >= rd_idx))
            begin
                cell_next[i] = cell_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.exec && do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.exec && do_del)
        begin
            count_next = count_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        if (cmd.capture)
        begin
            op_reg  <= opcode_t'(opcode);
            val_reg <= value;
            pos_reg <= position;
        end
        if (cmd.exec)
        begin
            step_reg <= IDX_W'(1);
        end
        else if (cmd.dump_next)
        begin
            step_reg <= step_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.exec && has_res) || cmd.dump_next)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && has_res)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
            out_count_reg  <= 5'(count_next);
            out_last_reg   <= res_last;
        end
        else if (cmd.dump_next)
        begin
            out_status_reg <= ST_OK;
            out_value_reg  <= rd_data;
            out_count_reg  <= 5'(count_reg);
            out_last_reg   <= sts.dump_final;
        end
    end

    assign sts.slot_free  = !out_valid_reg || out_ready;
    assign sts.dump_multi = ((op_reg == OP_DUMP_FWD) || (op_reg == OP_DUMP_BACK))
                            && (count_reg > CNT_W'(1));
    assign sts.dump_final = (CNT_W'(step_cur) == count_m1);

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign result_value  = out_value_reg;
    assign element_count = out_count_reg;
    assign last          = out_last_reg;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the positional list engine core.
module testbench;
    import ple_pkg::*;

    localparam int RANDOM_ITEMS = 145;
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES  = 60;    // long output stall, well past the block's buffering
    localparam int DRAIN_CYCLES = 40;    // covers a full 16-element dump plus slack

    // one output word as the block should present it
    typedef struct packed {
        status_t            st;
        logic signed [31:0] val;
        logic [4:0]         cnt;
        logic               fin;
    } list_word_t;

    // one input word, with an optional hand-written expectation
    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] val;
        logic [7:0]         pos;
        logic               typed;
        list_word_t         want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [3:0]         opcode = 4'd0;
    logic signed [31:0] value = 32'sd0;
    logic [7:0]         position = 8'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic [4:0]         element_count;
    logic               last;

    // shadow copy of the list, front element in cell 0
    logic signed [31:0] shadow_cells [DEPTH];
    int                 shadow_count = 0;

    list_word_t         due_words [$];    // words still owed by the block, oldest first
    list_word_t         fresh_words [$];  // words worked out for the input just accepted
    stim_row_t          stim_table [$];

    int                 errors = 0;
    int                 quiet_cycles = 0;
    bit                 hold_off_req = 1'b0;  // asks the receiver for one long stall
    bit                 steady = 1'b0;        // no idling on either side while set

    positional_list_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .result_value  (result_value),
        .element_count (element_count),
        .last          (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow list. Words are noted after the state change, so the count
    // carried is the occupancy after the operation.
    // ------------------------------------------------------------------
    task automatic note_word(input status_t st, input logic signed [31:0] v, input logic fin);
        list_word_t w;
        w.st  = st;
        w.val = v;
        w.cnt = shadow_count[4:0];
        w.fin = fin;
        fresh_words.push_back(w);
    endtask

    // open a gap before cell idx and drop v into it
    task automatic shadow_insert(input int idx, input logic signed [31:0] v);
        int i;
        for (i = shadow_count; i > idx; i--)
            shadow_cells[i] = shadow_cells[i - 1];
        shadow_cells[idx] = v;
        shadow_count++;
    endtask

    // close the list over cell idx and hand back what was there
    function automatic logic signed [31:0] shadow_remove(input int idx);
        logic signed [31:0] gone;
        int                 i;
        gone = shadow_cells[idx];
        for (i = idx; i + 1 < shadow_count; i++)
            shadow_cells[i] = shadow_cells[i + 1];
        shadow_count--;
        return gone;
    endfunction

    task automatic apply_to_shadow(input logic [3:0] op, input logic signed [31:0] v,
                                   input logic [7:0] pos);
        logic signed [31:0] gone;
        logic               hit;
        int                 i;
        int                 idx;
        case (op)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (shadow_count >= DEPTH)
                    note_word(ST_FULL, 32'sd0, 1'b1);
                else
                begin
                    shadow_insert(op == OP_INS_FRONT ? 0 : shadow_count, v);
                    note_word(ST_OK, v, 1'b1);
                end
            end
            OP_INS_AT:
            begin
                // position zero, then empty list, then past the end, then full
                if (pos == 8'd0)
                    note_word(ST_BADPOS, 32'sd0, 1'b1);
                else if (shadow_count == 0)
                begin
                    shadow_insert(0, v);
                    note_word(ST_OK, v, 1'b1);
                end
                else if (int'(pos) > shadow_count)
                    note_word(ST_NOPOS, 32'sd0, 1'b1);
                else if (shadow_count >= DEPTH)
                    note_word(ST_FULL, 32'sd0, 1'b1);
                else
                begin
                    shadow_insert(int'(pos) - 1, v);
                    note_word(ST_OK, v, 1'b1);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (shadow_count == 0)
                    note_word(ST_EMPTY, 32'sd0, 1'b1);
                else
                begin
                    gone = shadow_remove(op == OP_DEL_FRONT ? 0 : shadow_count - 1);
                    note_word(ST_OK, gone, 1'b1);
                end
            end
            OP_DEL_AT:
            begin
                // position zero is checked before the empty list
                if (pos == 8'd0)
                    note_word(ST_BADPOS, 32'sd0, 1'b1);
                else if (shadow_count == 0)
                    note_word(ST_EMPTY, 32'sd0, 1'b1);
                else if (int'(pos) > shadow_count)
                    note_word(ST_NOPOS, 32'sd0, 1'b1);
                else
                begin
                    gone = shadow_remove(int'(pos) - 1);
                    note_word(ST_OK, gone, 1'b1);
                end
            end
            OP_SEARCH:
            begin
                if (shadow_count == 0)
                    note_word(ST_EMPTY, 32'sd0, 1'b1);
                else
                begin
                    hit = 1'b0;
                    for (i = 0; i < shadow_count; i++)
                        if (shadow_cells[i] == v)
                            hit = 1'b1;
                    note_word(hit ? ST_FOUND : ST_NOTFOUND, 32'sd0, 1'b1);
                end
            end
            OP_DUMP_FWD, OP_DUMP_BACK:
            begin
                // empty list still gives one word, marked last
                if (shadow_count == 0)
                    note_word(ST_EMPTY, 32'sd0, 1'b1);
                else
                    for (i = 0; i < shadow_count; i++)
                    begin
                        idx = (op == OP_DUMP_FWD) ? i : shadow_count - 1 - i;
                        note_word(ST_OK, shadow_cells[idx], i + 1 == shadow_count);
                    end
            end
            default:
                ;  // opcodes nine to fifteen are dropped without a word
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender. Inputs move on the falling edge, acceptance is seen on the
    // rising edge. Valid is raised regardless of ready and held until taken.
    // ------------------------------------------------------------------
    task automatic offer_word(input stim_row_t row);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= row.op;
        value    <= row.val;
        position <= row.pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_to_shadow(row.op, row.val, row.pos);
        // a typed row stands in for the shadow's word; the shadow state still moves
        if (row.typed)
        begin
            fresh_words.delete();
            due_words.push_back(row.want);
        end
        else
            while (fresh_words.size() != 0)
                due_words.push_back(fresh_words.pop_front());
    endtask

    task automatic add_row(input logic [3:0] op, input logic signed [31:0] v,
                           input logic [7:0] pos, input logic typed, input status_t st,
                           input logic signed [31:0] rv, input logic [4:0] cnt);
        stim_row_t row;
        row.op       = op;
        row.val      = v;
        row.pos      = pos;
        row.typed    = typed;
        row.want.st  = st;
        row.want.val = rv;
        row.want.cnt = cnt;
        row.want.fin = 1'b1;
        stim_table.push_back(row);
    endtask

    initial
    begin : stimulus
        stim_row_t row;
        int        counted;
        int        fill_goal;
        int        roll;

        // Directed part, list empty at the start. Typed rows carry the obvious
        // answer; the rest are left to the shadow list.
        add_row(OP_DEL_FRONT, 32'sd5,        8'd0,   1'b1, ST_EMPTY,  32'sd0,        5'd0);
        add_row(OP_DEL_BACK,  32'sd5,        8'd0,   1'b1, ST_EMPTY,  32'sd0,        5'd0);
        add_row(OP_DEL_AT,    32'sd5,        8'd0,   1'b1, ST_BADPOS, 32'sd0,        5'd0);
        add_row(OP_DEL_AT,    32'sd5,        8'd255, 1'b1, ST_EMPTY,  32'sd0,        5'd0);
        add_row(OP_SEARCH,    32'sd0,        8'd1,   1'b1, ST_EMPTY,  32'sd0,        5'd0);
        add_row(OP_DUMP_FWD,  32'sd0,        8'd0,   1'b1, ST_EMPTY,  32'sd0,        5'd0);
        add_row(OP_DUMP_BACK, 32'sd0,        8'd0,   1'b1, ST_EMPTY,  32'sd0,        5'd0);
        add_row(OP_INS_AT,    32'sd7,        8'd0,   1'b1, ST_BADPOS, 32'sd0,        5'd0);
        // positioned insert on an empty list takes any nonzero position
        add_row(OP_INS_AT,    32'h7FFFFFFF,  8'd255, 1'b1, ST_OK,     32'h7FFFFFFF,  5'd1);
        add_row(OP_INS_FRONT, 32'h80000000,  8'd0,   1'b1, ST_OK,     32'h80000000,  5'd2);
        add_row(OP_INS_BACK,  32'sd0,        8'd0,   1'b1, ST_OK,     32'sd0,        5'd3);
        // count + 1 is past the end for a positioned insert
        add_row(OP_INS_AT,    32'sd9,        8'd4,   1'b1, ST_NOPOS,  32'sd0,        5'd3);
        add_row(OP_INS_AT,    32'sd9,        8'd255, 1'b1, ST_NOPOS,  32'sd0,        5'd3);
        add_row(OP_INS_AT,    -32'sd1,       8'd2,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_INS_AT,    32'sd1234,     8'd1,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_SEARCH,    -32'sd1,       8'd0,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_SEARCH,    32'sd5,        8'd0,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_DUMP_FWD,  32'sd0,        8'd0,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_DUMP_BACK, 32'sd0,        8'd0,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_DEL_AT,    32'sd0,        8'd6,   1'b1, ST_NOPOS,  32'sd0,        5'd5);
        add_row(OP_DEL_AT,    32'sd0,        8'd3,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_DEL_FRONT, 32'sd0,        8'd0,   1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(OP_DEL_BACK,  32'sd0,        8'd0,   1'b0, ST_OK,     32'sd0,        5'd0);
        // unused opcodes: swallowed, no word back
        add_row(4'd9,         -32'sd1,       8'd255, 1'b0, ST_OK,     32'sd0,        5'd0);
        add_row(4'd15,        32'h55555555,  8'hAA,  1'b0, ST_OK,     32'sd0,        5'd0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
            offer_word(stim_table[i]);

        // Random part, run as episodes that steer the occupancy towards a goal.
        // The first goal is a full list so the full cases come early; later
        // goals sweep empty, near-empty, half, near-full and full.
        counted   = 0;
        fill_goal = DEPTH;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 25 == 0 && counted != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       fill_goal = 0;
                    1:       fill_goal = 2;
                    2:       fill_goal = DEPTH / 2;
                    3:       fill_goal = DEPTH - 1;
                    default: fill_goal = DEPTH;
                endcase
            end
            steady = (counted >= 90 && counted < 130);

            roll = $urandom_range(0, 99);
            if (roll < 4)
                row.op = 4'($urandom_range(9, 15));
            else if (roll < 12)
                row.op = $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_BACK;
            else if (roll < 24)
                row.op = OP_SEARCH;
            else if (shadow_count < fill_goal ||
                     (shadow_count == fill_goal && $urandom_range(0, 1) == 1))
                row.op = 4'($urandom_range(0, 2));
            else
                row.op = 4'($urandom_range(3, 5));

            // values: often one already held so searches hit, some extremes
            roll = $urandom_range(0, 99);
            if (roll < 30 && shadow_count > 0)
                row.val = shadow_cells[$urandom_range(0, shadow_count - 1)];
            else if (roll < 40)
            begin
                case ($urandom_range(0, 3))
                    0:       row.val = 32'h80000000;
                    1:       row.val = 32'h7FFFFFFF;
                    2:       row.val = 32'sd0;
                    default: row.val = -32'sd1;
                endcase
            end
            else
                row.val = $urandom;

            // positions: mostly legal, with zero, the end boundary and junk
            roll = $urandom_range(0, 99);
            if (roll < 10)
                row.pos = 8'd0;
            else if (roll < 20)
                row.pos = 8'($urandom_range(0, 255));
            else if (roll < 30)
                row.pos = 8'(shadow_count + $urandom_range(0, 1));
            else
                row.pos = 8'($urandom_range(1, shadow_count + 1));

            row.typed = 1'b0;
            row.want  = '0;

            if (row.op <= OP_DUMP_BACK)
            begin
                // one long output stall while the sender keeps offering words
                if (counted == 40)
                    hold_off_req = 1'b1;
                counted++;
            end
            offer_word(row);
        end

        steady = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // the watchdog bounds this wait
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, one long hold when asked.
    // ------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every word taken is matched against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_words
        list_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_words.size() == 0)
            begin
                $display("%0t: unexpected word: status %0d value %0d count %0d last %0d",
                         $time, status, result_value, element_count, last);
                errors++;
            end
            else
            begin
                want = due_words.pop_front();
                if (status !== want.st || result_value !== want.val ||
                    element_count !== want.cnt || last !== want.fin)
                begin
                    $display("%0t: mismatch: expected status %0d value %0d count %0d last %0d,",
                             $time, want.st, want.val, want.cnt, want.fin,
                             " got status %0d value %0d count %0d last %0d",
                             status, result_value, element_count, last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d words still owed",
                         $time, STALL_LIMIT, due_words.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
